// ----- rtl/lsq_pkg.sv -----
package lsq_pkg;

  localparam int unsigned VertexW = 8;
  localparam int unsigned HeldW   = 9;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STAT_UPDATED   = 3'd0,
    STAT_NOT_IMPR  = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_EMPTY_ERR = 3'd3,
    STAT_FULL_ERR  = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [VertexW-1:0] vertex_id;
    logic signed [15:0] key_primary;
    logic [7:0]         key_secondary;
    logic [7:0]         key_tertiary;
  } in_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [VertexW-1:0] vertex_out;
    logic               queue_empty;
    logic [HeldW-1:0]   entries_held;
  } out_rsp_t;

  // One queue slot as it sits in the slot memory.
  typedef struct packed {
    logic [VertexW-1:0] vertex;
    logic [15:0]        primary;
    logic [7:0]         secondary;
    logic [7:0]         tertiary;
  } entry_t;

  // Flipping the sign bit of the primary part makes a plain unsigned compare
  // of the concatenation follow the lexicographic key order.
  function automatic logic [31:0] key_code(entry_t e);
    key_code = {~e.primary[15], e.primary[14:0], e.secondary, e.tertiary};
  endfunction

endpackage

// ----- rtl/linear_scan_priority_queue.sv -----
// Priority queue of up to ENTRIES (vertex, key) pairs held unsorted in one
// single-port-read slot memory. Each request returns exactly one response.
// An update or remove-min walks the held slots one per cycle through the
// memory read port, and its response is registered once the walk ends. An
// update that finds its vertex stops the walk early. Clear, the unused
// request code and remove on an empty queue go to the response without a
// walk. One request is worked on at a time; a finished response waits in
// the output register while the next request is taken. A stalled response
// that still holds the output register keeps the block in its response
// state until that register is free. The slot memory needs no clearing
// after reset.
module linear_scan_priority_queue
  import lsq_pkg::*;
#(
  parameter int unsigned ENTRIES = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_REM  = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic rv_q, rv_d;
  logic [IdxW-1:0] ri_q, ri_d;
  in_req_t req_q, req_d;
  status_e res_status_q, res_status_d;
  logic [VertexW-1:0] res_vtx_q, res_vtx_d;
  logic [31:0] best_key_q, best_key_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic [VertexW-1:0] best_vtx_q, best_vtx_d;
  entry_t last_q, last_d;
  logic out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, out_rsp_d;

  logic mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t mem_wdata;
  logic mem_re;
  entry_t mem_rdata;
  entry_t new_entry;
  logic rsp_load;
  logic scan_done;
  logic issue_ok;

  lsq_mem #(
    .DEPTH(ENTRIES),
    .AW   (IdxW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(rd_ptr_q[IdxW-1:0]),
    .rdata_o(mem_rdata)
  );

  assign new_entry = '{vertex:    req_q.vertex_id,
                       primary:   req_q.key_primary,
                       secondary: req_q.key_secondary,
                       tertiary:  req_q.key_tertiary};

  // Every read has returned and nothing more is left to issue.
  assign scan_done = !rv_q && (rd_ptr_q >= cnt_q);
  assign issue_ok  = rd_ptr_q < cnt_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_ptr_d     = rd_ptr_q;
    rv_d         = 1'b0;
    ri_d         = rd_ptr_q[IdxW-1:0];
    req_d        = req_q;
    res_status_d = res_status_q;
    res_vtx_d    = res_vtx_q;
    best_key_d   = best_key_q;
    best_idx_d   = best_idx_q;
    best_vtx_d   = best_vtx_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    mem_waddr    = ri_q;
    mem_wdata    = new_entry;
    mem_re       = 1'b0;
    rsp_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          rd_ptr_d     = '0;
          res_status_d = STAT_NOT_IMPR;
          res_vtx_d    = '0;
          case (in_req_i.req_type)
            REQ_UPDATE: state_d = ST_UPD;
            REQ_REMOVE: begin
              if (cnt_q == '0) begin
                res_status_d = STAT_EMPTY_ERR;
                state_d      = ST_RESP;
              end else begin
                state_d = ST_REM;
              end
            end
            REQ_CLEAR: begin
              cnt_d        = '0;
              res_status_d = STAT_CLEARED;
              state_d      = ST_RESP;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end

      ST_UPD: begin
        if (rv_q && (mem_rdata.vertex == req_q.vertex_id)) begin
          // Found the vertex; the scan stops here.
          state_d = ST_RESP;
          if (key_code(new_entry) < key_code(mem_rdata)) begin
            mem_we       = 1'b1;
            mem_waddr    = ri_q;
            res_status_d = STAT_UPDATED;
          end else begin
            res_status_d = STAT_NOT_IMPR;
          end
        end else if (scan_done) begin
          state_d = ST_RESP;
          if (cnt_q == CntW'(ENTRIES)) begin
            res_status_d = STAT_FULL_ERR;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = cnt_q[IdxW-1:0];
            cnt_d        = cnt_q + 1'b1;
            res_status_d = STAT_UPDATED;
          end
        end else if (issue_ok) begin
          mem_re   = 1'b1;
          rv_d     = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
      end

      ST_REM: begin
        if (rv_q) begin
          last_d = mem_rdata;
          if ((ri_q == '0) || (key_code(mem_rdata) < best_key_q)) begin
            best_key_d = key_code(mem_rdata);
            best_idx_d = ri_q;
            best_vtx_d = mem_rdata.vertex;
          end
        end
        if (scan_done) begin
          // The last slot read is the last held slot; it moves into the hole.
          mem_we       = 1'b1;
          mem_waddr    = best_idx_q;
          mem_wdata    = last_q;
          cnt_d        = cnt_q - 1'b1;
          res_status_d = STAT_REMOVED;
          res_vtx_d    = best_vtx_q;
          state_d      = ST_RESP;
        end else if (issue_ok) begin
          mem_re   = 1'b1;
          rv_d     = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_rsp_d              = out_rsp_q;
    out_valid_d            = out_valid_q && out_stall_i;
    if (rsp_load) begin
      out_valid_d            = 1'b1;
      out_rsp_d.status       = res_status_q;
      out_rsp_d.vertex_out   = res_vtx_q;
      out_rsp_d.queue_empty  = (cnt_q == '0);
      out_rsp_d.entries_held = HeldW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q         <= ri_d;
    req_q        <= req_d;
    res_status_q <= res_status_d;
    res_vtx_q    <= res_vtx_d;
    best_key_q   <= best_key_d;
    best_idx_q   <= best_idx_d;
    best_vtx_q   <= best_vtx_d;
    last_q       <= last_d;
    out_rsp_q    <= out_rsp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES))
    else $error("entry count exceeds the queue depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (CntW'(ri_q) < cnt_q))
    else $error("slot read beyond the held entries");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_UPD) || (state_q == ST_REM)))
    else $error("slot write outside a scan");

  a_no_read_in_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) |-> !rv_q)
    else $error("read still in flight after the scan ended");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REM && scan_done) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("remove did not shrink the queue by one");

endmodule

// ----- rtl/lsq_mem.sv -----
module lsq_mem
  import lsq_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
